FILE: hdl/qps_pkg.sv
package qps_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned SPEED_W = 40;
	localparam int unsigned MAG_W   = 39;
	localparam int unsigned CFG16_W = 16;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned DEN_W   = 64;
	localparam int unsigned PG_W    = 32;

	// 60 s/min * 1e6 us/s * 10 (EDGES_PER_MEASURE) * 256 (Q.8) = 153600000000, which needs 38 bits.
	localparam int unsigned NUM_W = 38;
	localparam logic [NUM_W-1:0] SPEED_NUM = 38'd153600000000;
	localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};

	localparam logic [CNT_W-1:0] EDGES_PER_MEASURE = 4'd10;

	// The multiplier takes two bits of elapsed time per step.
	localparam int unsigned MUL_STEPS = TIME_W / 2;
	localparam int unsigned STEP_W    = 6;

	localparam logic [CFG16_W-1:0] PPR_RESET     = 16'd7;
	localparam logic [CFG16_W-1:0] GEAR_RESET    = 16'd100;
	localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd1000000;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PPR     = 2'd0,
		REG_GEAR    = 2'd1,
		REG_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_HOLD
	} top_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_MUL,
		C_PREP,
		C_DIV
	} calc_state_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] elapsed;
	} calc_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] mag;
	} calc_rsp_t;

endpackage

FILE: hdl/qps_if.sv
interface qps_sample_if;
	import qps_pkg::*;
	logic              valid;
	logic              ready;
	logic              pin_a;
	logic              pin_b;
	logic [TIME_W-1:0] time_us;

	modport source(output valid, output pin_a, output pin_b, output time_us, input ready);
	modport sink(input valid, input pin_a, input pin_b, input time_us, output ready);
endinterface

interface qps_result_if;
	import qps_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [POS_W-1:0]   position;
	logic signed [SPEED_W-1:0] speed_rpm_q8;
	logic                      moved;

	modport source(output valid, output position, output speed_rpm_q8, output moved,
		input ready);
	modport sink(input valid, input position, input speed_rpm_q8, input moved,
		output ready);
endinterface

interface qps_cfg_if;
	import qps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/quadrature_position_and_speed.sv
// Channel  | Modport | Payload                          | Transfer when
// ---------+---------+----------------------------------+-----------------------
// samples  | sink    | pin_a, pin_b, time_us            | valid && ready
// results  | source  | position, speed_rpm_q8, moved    | valid && ready
// cfg      | sink    | index, data                      | valid && ready (always ready)
//
// A sample that does not complete a measurement is taken in the idle state; the next sample
// is taken in the following cycle as long as the result register is free or drains.
// A measuring sample's result waits for the serial speed unit: 16 multiply steps of two bits each
// and 38 one-bit division steps; the division is skipped when the divisor is zero.
// Reset is asynchronous and active low; it loads the register defaults and zeroes the state.
// While a result waits in the output register, one more sample can be taken and finished.
module quadrature_position_and_speed #(
	parameter logic [qps_pkg::CNT_W-1:0] MEASURE_EDGES = qps_pkg::EDGES_PER_MEASURE
) (
	input  logic          clk,
	input  logic          arst_n,
	qps_sample_if.sink    samples,
	qps_result_if.source  results,
	qps_cfg_if.sink       cfg
);
	import qps_pkg::*;

	top_state_t state_q, state_nxt;

	logic [CFG16_W-1:0] ppr_q;
	logic [CFG16_W-1:0] gear_q;
	logic [TIME_W-1:0]  timeout_q;

	logic               last_a_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   rcnt_q;
	logic [TIME_W-1:0]  lmt_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic               pend_moved_q;

	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic               out_moved_q;

	logic               in_xfer;
	logic               slot_free;
	logic               moved;
	logic [POS_W-1:0]   pos_nxt;
	logic               neg_nxt;
	logic [CNT_W-1:0]   cnt_inc;
	logic               measure;
	logic [TIME_W-1:0]  elapsed;
	logic [MAG_W-1:0]   mag_aged;

	logic               take;
	logic               start_calc;
	logic               out_direct;
	logic               out_hold;

	calc_req_t          req;
	calc_rsp_t          rsp;

	function automatic logic [SPEED_W-1:0] signed_speed(input logic [MAG_W-1:0] mag,
		input logic neg);
		logic [SPEED_W-1:0] ext;
		ext = {1'b0, mag};
		return neg ? (~ext + 1'b1) : ext;
	endfunction

	assign in_xfer   = samples.valid && samples.ready;
	assign slot_free = !out_valid_q || results.ready;

	assign moved    = samples.pin_a ^ last_a_q;
	assign pos_nxt  = !moved ? pos_q
		: (samples.pin_b != samples.pin_a) ? pos_q + 1'b1 : pos_q - 1'b1;
	assign neg_nxt  = moved ? (samples.pin_b == samples.pin_a) : neg_q;
	assign cnt_inc  = rcnt_q + 1'b1;
	assign measure  = moved && samples.pin_a && (cnt_inc >= MEASURE_EDGES);
	assign elapsed  = samples.time_us - lmt_q;
	assign mag_aged = (elapsed > timeout_q) ? '0 : mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		take       = 1'b0;
		start_calc = 1'b0;
		out_direct = 1'b0;
		out_hold   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				take = 1'b1;
				if (samples.valid) begin
					if (measure) begin
						start_calc = 1'b1;
						state_nxt  = S_CALC;
					end else if (slot_free) begin
						out_direct = 1'b1;
					end else begin
						state_nxt = S_HOLD;
					end
				end
			end
			S_CALC: begin
				if (rsp.done) state_nxt = S_HOLD;
			end
			S_HOLD: begin
				if (slot_free) begin
					out_hold  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign samples.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= PPR_RESET;
			gear_q    <= GEAR_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PPR:     ppr_q     <= cfg.data[CFG16_W-1:0];
				REG_GEAR:    gear_q    <= cfg.data[CFG16_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg.data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q     <= 1'b0;
			pos_q        <= '0;
			rcnt_q       <= '0;
			lmt_q        <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			pend_moved_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				last_a_q     <= samples.pin_a;
				pos_q        <= pos_nxt;
				neg_q        <= neg_nxt;
				pend_moved_q <= moved;
				if (measure) begin
					// The elapsed time after a measurement is zero, so no timeout applies.
					rcnt_q <= '0;
					lmt_q  <= samples.time_us;
				end else begin
					if (moved && samples.pin_a) rcnt_q <= cnt_inc;
					mag_q <= mag_aged;
				end
			end
			if ((state_q == S_CALC) && rsp.done) begin
				mag_q <= rsp.mag;
			end
		end
	end

	assign req.start   = start_calc;
	assign req.elapsed = elapsed;

	qps_speed_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.ppr    (ppr_q),
		.gear   (gear_q),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_direct || out_hold) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A result that waits in the hold state keeps its fields in the state registers.
	always_ff @(posedge clk) begin
		if (out_direct) begin
			out_pos_q   <= pos_nxt;
			out_speed_q <= signed_speed(mag_aged, neg_nxt);
			out_moved_q <= moved;
		end else if (out_hold) begin
			out_pos_q   <= pos_q;
			out_speed_q <= signed_speed(mag_q, neg_q);
			out_moved_q <= pend_moved_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.position     = $signed(out_pos_q);
	assign results.speed_rpm_q8 = $signed(out_speed_q);
	assign results.moved        = out_moved_q;

endmodule

FILE: hdl/qps_speed_calc.sv
module qps_speed_calc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [qps_pkg::CFG16_W-1:0]    ppr,
	input  logic [qps_pkg::CFG16_W-1:0]    gear,
	input  qps_pkg::calc_req_t             req,
	output qps_pkg::calc_rsp_t             rsp
);
	import qps_pkg::*;

	calc_state_t state_q, state_nxt;

	logic [TIME_W-1:0] el_q;
	logic [PG_W-1:0]   pg_q;
	logic [DEN_W-1:0]  acc_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [MAG_W-1:0]  mag_q;

	logic [PG_W-1:0]   pg_prod;
	logic [PG_W+1:0]   partial;
	logic [DEN_W-1:0]  acc_nxt;
	logic [NUM_W:0]    trial;
	logic [NUM_W:0]    diff;
	logic              fits;
	logic              mul_last;
	logic              div_last;

	assign pg_prod = ppr * gear;

	// Left to right over the elapsed time, two bits at a time.
	assign partial = ({(PG_W+2){el_q[TIME_W-2]}} & {2'b00, pg_q})
		+ ({(PG_W+2){el_q[TIME_W-1]}} & {1'b0, pg_q, 1'b0});
	assign acc_nxt = {acc_q[DEN_W-3:0], 2'b00} + {{(DEN_W-PG_W-2){1'b0}}, partial};

	// Restoring division step; the divisor sits in acc_q.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (acc_q[DEN_W-1:NUM_W+1] == '0) && (acc_q[NUM_W:0] <= trial);
	assign diff  = trial - acc_q[NUM_W:0];

	assign mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
	assign div_last = (step_q == STEP_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= ((state_q == C_PREP) && (acc_q == '0))
				|| ((state_q == C_DIV) && div_last);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			C_IDLE: if (req.start) state_nxt = C_MUL;
			C_MUL:  if (mul_last) state_nxt = C_PREP;
			C_PREP: state_nxt = (acc_q == '0) ? C_IDLE : C_DIV;
			C_DIV:  if (div_last) state_nxt = C_IDLE;
			default: state_nxt = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					el_q   <= req.elapsed;
					pg_q   <= pg_prod;
					acc_q  <= '0;
					step_q <= '0;
				end
			end
			C_MUL: begin
				acc_q  <= acc_nxt;
				el_q   <= {el_q[TIME_W-3:0], 2'b00};
				step_q <= mul_last ? '0 : step_q + 1'b1;
			end
			C_PREP: begin
				rem_q <= '0;
				num_q <= SPEED_NUM;
				if (acc_q == '0) begin
					mag_q <= MAG_MAX;
				end
			end
			C_DIV: begin
				rem_q  <= fits ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], fits};
				step_q <= step_q + 1'b1;
				if (div_last) begin
					mag_q <= {1'b0, num_q[NUM_W-2:0], fits};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.mag  = mag_q;

endmodule

FILE: hdl/qps_checker.sv
module qps_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [qps_pkg::POS_W-1:0]      position,
	input logic signed [qps_pkg::SPEED_W-1:0]    speed_rpm_q8,
	input logic                                  moved
);
	import qps_pkg::*;

	logic             in_xfer;
	logic             out_xfer;
	logic [1:0]       open_q;
	logic [POS_W-1:0] prev_pos_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= '0;
			prev_pos_q <= '0;
		end else begin
			if (in_xfer && !out_xfer) open_q <= open_q + 1'b1;
			else if (!in_xfer && out_xfer) open_q <= open_q - 1'b1;
			if (out_xfer) prev_pos_q <= position;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position) && $stable(speed_rpm_q8)
			&& $stable(moved))
		else $error("stalled result changed");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 2'd2)
		else $error("more samples in flight than the block can hold");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 2'd0)
		else $error("result without a pending sample");

	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (moved ? (position == prev_pos_q + 1'b1 || position == prev_pos_q - 1'b1)
			: (position == prev_pos_q)))
		else $error("position step does not match moved flag");

endmodule

bind quadrature_position_and_speed qps_checker u_qps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.position     (results.position),
	.speed_rpm_q8 (results.speed_rpm_q8),
	.moved        (results.moved)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import qps_pkg::*;

	localparam int CLK_HALF_NS   = 5;
	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam int STALL_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 100;
	localparam int REPORT_LIMIT  = 10;

	// Index 3 has no register behind it, so a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Channel levels along the forward quadrature cycle: AB = 00, 10, 11, 01.
	localparam logic [3:0] CYCLE_A = 4'b0110;
	localparam logic [3:0] CYCLE_B = 4'b1100;

	typedef struct packed {
		logic signed [POS_W-1:0]   position;
		logic signed [SPEED_W-1:0] speed;
		logic                      moved;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;

	qps_sample_if sample_ch ();
	qps_result_if result_ch ();
	qps_cfg_if    cfg_ch ();

	quadrature_position_and_speed dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Decoder image, updated as each sample transfer completes.
	logic [CFG16_W-1:0] ppr_reg       = PPR_RESET;
	logic [CFG16_W-1:0] gear_reg      = GEAR_RESET;
	logic [TIME_W-1:0]  timeout_reg   = TIMEOUT_RESET;
	logic               prev_a        = 1'b0;
	logic [POS_W-1:0]   edge_count    = '0;
	logic [CNT_W-1:0]   rise_count    = '0;
	logic [TIME_W-1:0]  measure_stamp = '0;
	logic [MAG_W-1:0]   speed_mag     = '0;
	logic               reversing     = 1'b0;

	reading_t pending_readings[$];
	int       mismatches    = 0;
	bit       sender_gaps   = 1'b1;
	bit       receiver_gaps = 1'b1;
	bit       stall_request = 1'b0;

	// Stimulus cursor for the motion generator.
	int                gray_idx  = 0;
	int                direction = 1;
	logic [TIME_W-1:0] clock_us  = '0;

	function automatic reading_t decode_sample(input logic a, input logic b,
		input logic [TIME_W-1:0] t);
		reading_t          r;
		logic [TIME_W-1:0] elapsed;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  quo;
		r.moved = (a != prev_a);
		if (r.moved) begin
			if (b != a) begin
				edge_count = edge_count + 1'b1;
				reversing = 1'b0;
			end else begin
				edge_count = edge_count - 1'b1;
				reversing = 1'b1;
			end
			prev_a = a;
			if (a) begin
				rise_count = rise_count + 1'b1;
				if (rise_count >= EDGES_PER_MEASURE) begin
					elapsed = t - measure_stamp;
					den = DEN_W'(elapsed) * DEN_W'(ppr_reg) * DEN_W'(gear_reg);
					if (den == '0) begin
						speed_mag = MAG_MAX;
					end else begin
						quo = DEN_W'(SPEED_NUM) / den;
						speed_mag = (quo > DEN_W'(MAG_MAX)) ? MAG_MAX : quo[MAG_W-1:0];
					end
					measure_stamp = t;
					rise_count = '0;
				end
			end
		end
		elapsed = t - measure_stamp;
		if (elapsed > timeout_reg)
			speed_mag = '0;
		r.position = edge_count;
		r.speed = reversing ? (SPEED_W'(0) - {1'b0, speed_mag}) : {1'b0, speed_mag};
		return r;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_sample(input logic a, input logic b, input logic [TIME_W-1:0] t);
		while (sender_gaps && $urandom_range(0, 99) < 8) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.pin_a   <= a;
		sample_ch.pin_b   <= b;
		sample_ch.time_us <= t;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		pending_readings.push_back(decode_sample(a, b, t));
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_PPR:     ppr_reg = value[CFG16_W-1:0];
			REG_GEAR:    gear_reg = value[CFG16_W-1:0];
			REG_TIMEOUT: timeout_reg = value;
			default:     ;
		endcase
	endtask

	// Registers change only with the decoder empty; the upper data bits of the
	// 16-bit registers carry junk that must be dropped.
	task automatic configure(input logic [CFG16_W-1:0] ppr, input logic [CFG16_W-1:0] gear,
		input logic [TIME_W-1:0] tmo, input bit poke_unused);
		wait_drained();
		write_reg(REG_PPR, {CFG16_W'($urandom()), ppr});
		write_reg(REG_GEAR, {CFG16_W'($urandom()), gear});
		write_reg(REG_TIMEOUT, tmo);
		if (poke_unused)
			write_reg(REG_UNUSED, $urandom());
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly clean quadrature motion with random dwell and speed, plus direction
	// reversals, skipped states, time jumps past the timeout and stray timestamps.
	task automatic run_motion(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				direction = -direction;
			if (pick < 75)
				gray_idx = (gray_idx + direction) & 3;
			else if (pick >= 90)
				gray_idx = $urandom_range(0, 3);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				clock_us = clock_us;
			else if (pick < 6)
				clock_us = clock_us + $urandom_range(0, 3_000_000);
			else if (pick < 8)
				clock_us = $urandom();
			else
				clock_us = clock_us + $urandom_range(1, 400);
			send_sample(CYCLE_A[gray_idx[1:0]], CYCLE_B[gray_idx[1:0]], clock_us);
		end
	endtask

	task automatic test_edge_counting();
		send_sample(1'b0, 1'b0, '0);
		send_sample(1'b0, 1'b1, '1);
		send_sample(1'b1, 1'b1, '0);
		send_sample(1'b0, 1'b0, '0);
		// Nine more rising edges at the same timestamp: the tenth measures zero
		// elapsed time and saturates.
		for (int i = 0; i < 9; i++) begin
			send_sample(1'b1, 1'b0, '0);
			if (i < 8)
				send_sample(1'b0, 1'b1, '0);
		end
		send_sample(1'b1, 1'b1, 32'd5);
		send_sample(1'b0, 1'b1, 32'd6);
		send_sample(1'b1, 1'b1, 32'd8);
		send_sample(1'b1, 1'b1, 32'd2_000_000);
	endtask

	task automatic test_register_extremes();
		configure(16'd1, 16'd1, '1, 1'b0);
		run_motion(250);
		configure('1, '1, 32'd1, 1'b0);
		run_motion(150);
		configure('0, 16'd40000, TIMEOUT_RESET, 1'b1);
		run_motion(150);
		configure(16'd300, '0, 32'd500_000, 1'b0);
		run_motion(150);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 3; p++) begin
			configure(CFG16_W'($urandom_range(1, 2000)), CFG16_W'($urandom_range(1, 500)),
				$urandom_range(1000, 2_000_000), 1'b0);
			run_motion(250);
		end
	endtask

	task automatic test_time_wrap();
		configure(PPR_RESET, GEAR_RESET, TIMEOUT_RESET, 1'b0);
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		clock_us = 32'hFFFF_C000;
		run_motion(250);
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		sender_gaps = 1'b0;
		stall_request = 1'b1;
		run_motion(40);
		wait_drained();
		run_motion(40);
		sender_gaps = 1'b1;
	endtask

	initial begin
		arst_n            <= 1'b0;
		sample_ch.valid   <= 1'b0;
		sample_ch.pin_a   <= 1'b0;
		sample_ch.pin_b   <= 1'b0;
		sample_ch.time_us <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_PPR;
		cfg_ch.data       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_counting();
		test_register_extremes();
		test_random_settings();
		test_time_wrap();
		test_backpressure();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: random holds, and one long hold-off counted here on request.
	initial begin
		int hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold = STALL_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !(receiver_gaps && $urandom_range(0, 99) < 8);
			end
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				note_failure("result transfer with no reading outstanding");
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.position !== want.position)
					note_failure($sformatf("position: expected %0d, got %0d",
						want.position, result_ch.position));
				if (result_ch.speed_rpm_q8 !== want.speed)
					note_failure($sformatf("speed_rpm_q8: expected %0d, got %0d",
						want.speed, result_ch.speed_rpm_q8));
				if (result_ch.moved !== want.moved)
					note_failure($sformatf("moved: expected %0b, got %0b",
						want.moved, result_ch.moved));
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
